/* rtl/fss_pkg.sv */
package fss_pkg;

  localparam int unsigned MaxSlots = 2048;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned NeedW    = 5;
  localparam int unsigned ByteW    = 8;

  localparam logic [ByteW-1:0] EndMark    = 8'h00;
  localparam logic [ByteW-1:0] UnusedMark = 8'hE5;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxSlots - 1);

  typedef enum logic [1:0] {
    OutPlaced = 2'd0,
    OutNoEnd  = 2'd1,
    OutNoRoom = 2'd2
  } outcome_e;

  typedef struct packed {
    outcome_e        outcome;
    logic [IdxW-1:0] run_start;
    logic            relocate_end;
    logic [IdxW-1:0] old_end;
    logic [IdxW-1:0] new_end;
  } result_t;

endpackage

/* rtl/fss_scan.sv */
module fss_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [fss_pkg::ByteW-1:0]    first_byte_i,
  input  logic [fss_pkg::NeedW-1:0]    slots_needed_i,
  input  logic                         last_slot_i,
  output logic                         fin_o,
  output fss_pkg::result_t             res_o
);
  import fss_pkg::*;

  logic [IdxW-1:0]  slot_index_q, slot_index_d;
  logic [NeedW-1:0] run_length_q, run_length_d;
  logic             run_done_q, run_done_d;
  logic [IdxW-1:0]  run_last_q, run_last_d;
  logic             end_seen_q, end_seen_d;
  logic [IdxW-1:0]  end_at_q, end_at_d;
  logic [IdxW-1:0]  tail_begin_q, tail_begin_d;
  logic             tail_open_q, tail_open_d;

  logic            is_end, is_free;
  logic [NeedW-1:0] run_inc;
  logic [IdxW-1:0] start_idx, after_run;

  always_comb begin
    is_end  = (first_byte_i == EndMark);
    is_free = is_end || (first_byte_i == UnusedMark);
    run_inc = run_length_q + NeedW'(1);

    end_seen_d = end_seen_q | is_end;
    end_at_d   = (is_end && !end_seen_q) ? slot_index_q : end_at_q;

    run_length_d = run_length_q;
    run_done_d   = run_done_q;
    run_last_d   = run_last_q;
    if (!run_done_q) begin
      if (is_free) begin
        run_length_d = run_inc;
        if ((slots_needed_i != '0) && (run_inc == slots_needed_i)) begin
          run_done_d = 1'b1;
          run_last_d = slot_index_q;
        end
      end else begin
        run_length_d = '0;
      end
    end

    tail_open_d  = is_free;
    tail_begin_d = (is_free && !tail_open_q) ? slot_index_q : tail_begin_q;

    fin_o = last_slot_i || (slot_index_q == LastIdx);

    start_idx = run_last_d - IdxW'(slots_needed_i) + IdxW'(1);
    after_run = run_last_d + IdxW'(1);

    res_o              = '0;
    res_o.old_end      = end_seen_d ? end_at_d : '0;
    if (!end_seen_d) begin
      res_o.outcome = OutNoEnd;
    end else if (!run_done_d) begin
      res_o.outcome = OutNoRoom;
    end else if (end_at_d > run_last_d) begin
      res_o.outcome   = OutPlaced;
      res_o.run_start = start_idx;
    end else if (tail_open_d && (slot_index_q > run_last_d)) begin
      // end marker sits inside or before the run: move it past the run
      res_o.outcome      = OutPlaced;
      res_o.run_start    = start_idx;
      res_o.relocate_end = 1'b1;
      res_o.new_end      = (tail_begin_d > run_last_d) ? tail_begin_d : after_run;
    end else begin
      res_o.outcome = OutNoRoom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_index_q <= '0;
      run_length_q <= '0;
      run_done_q   <= 1'b0;
      run_last_q   <= '0;
      end_seen_q   <= 1'b0;
      end_at_q     <= '0;
      tail_begin_q <= '0;
      tail_open_q  <= 1'b0;
    end else if (step_i) begin
      if (fin_o) begin
        slot_index_q <= '0;
        run_length_q <= '0;
        run_done_q   <= 1'b0;
        run_last_q   <= '0;
        end_seen_q   <= 1'b0;
        end_at_q     <= '0;
        tail_begin_q <= '0;
        tail_open_q  <= 1'b0;
      end else begin
        slot_index_q <= slot_index_q + IdxW'(1);
        run_length_q <= run_length_d;
        run_done_q   <= run_done_d;
        run_last_q   <= run_last_d;
        end_seen_q   <= end_seen_d;
        end_at_q     <= end_at_d;
        tail_begin_q <= tail_begin_d;
        tail_open_q  <= tail_open_d;
      end
    end
  end

endmodule

/* rtl/free_directory_slot_run_finder.sv */
// Scans the directory slots of one cluster, one request per slot, and on the
// slot marked last (or slot 2047) delivers one result: placed, placed with the
// end marker relocated, no end marker, or no room. Each request passes an input
// register and then the scan/decision logic that loads the result register, so
// one slot is taken every cycle while the result register is free or being
// drained. Slots that are not last produce no result. slots_needed must be held
// through a scan.
module free_directory_slot_run_finder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fss_pkg::ByteW-1:0] first_byte_i,
  input  logic [fss_pkg::NeedW-1:0] slots_needed_i,
  input  logic                      last_slot_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output fss_pkg::outcome_e         outcome_o,
  output logic [fss_pkg::IdxW-1:0]  run_start_o,
  output logic                      relocate_end_o,
  output logic [fss_pkg::IdxW-1:0]  old_end_o,
  output logic [fss_pkg::IdxW-1:0]  new_end_o
);
  import fss_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic [NeedW-1:0] need_q;
  logic             last_q;

  logic    out_valid_q;
  result_t res_q, res_d;
  logic    step, fin;

  // advance the slot in the input register when the result slot can take it
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= first_byte_i;
      need_q <= slots_needed_i;
      last_q <= last_slot_i;
    end
  end

  fss_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .first_byte_i   (byte_q),
    .slots_needed_i (need_q),
    .last_slot_i    (last_q),
    .fin_o          (fin),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && fin) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = res_q.outcome;
  assign run_start_o    = res_q.run_start;
  assign relocate_end_o = res_q.relocate_end;
  assign old_end_o      = res_q.old_end;
  assign new_end_o      = res_q.new_end;

endmodule

/* rtl/fss_checker.sv */
module fss_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input fss_pkg::outcome_e        outcome_o,
  input logic [fss_pkg::IdxW-1:0] run_start_o,
  input logic                     relocate_end_o,
  input logic [fss_pkg::IdxW-1:0] old_end_o,
  input logic [fss_pkg::IdxW-1:0] new_end_o
);
  import fss_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_reloc_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relocate_end_o |-> outcome_o == OutPlaced)
    else $error("relocation without placement");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != OutPlaced
      |-> run_start_o == '0 && new_end_o == '0 && !relocate_end_o)
    else $error("failed outcome carries run data");

  a_noend_old: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OutNoEnd |-> old_end_o == '0)
    else $error("old end reported without end marker");

  // the old marker sits at or before the run, the new one past it
  a_reloc_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relocate_end_o |-> new_end_o > old_end_o)
    else $error("new end not above old end");

endmodule

bind free_directory_slot_run_finder fss_checker u_fss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .outcome_o      (outcome_o),
  .run_start_o    (run_start_o),
  .relocate_end_o (relocate_end_o),
  .old_end_o      (old_end_o),
  .new_end_o      (new_end_o)
);

/* dv/tb_top.sv */
module tb_top;
  import fss_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxPrinted = 40;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] first_byte_i   = '0;
  logic [NeedW-1:0] slots_needed_i = '0;
  logic             last_slot_i    = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  outcome_e         outcome_o;
  logic [IdxW-1:0]  run_start_o;
  logic             relocate_end_o;
  logic [IdxW-1:0]  old_end_o;
  logic [IdxW-1:0]  new_end_o;

  free_directory_slot_run_finder dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .first_byte_i,
    .slots_needed_i,
    .last_slot_i,
    .out_valid_o,
    .out_ready_i,
    .outcome_o,
    .run_start_o,
    .relocate_end_o,
    .old_end_o,
    .new_end_o
  );

  // scan state of the predictor
  logic [IdxW-1:0]  scan_idx;
  logic [NeedW-1:0] free_len;
  logic             run_found;
  logic [IdxW-1:0]  run_last;
  logic             end_marked;
  logic [IdxW-1:0]  end_idx;
  logic             tail_free;
  logic [IdxW-1:0]  tail_first;

  result_t     placement_q[$];
  result_t     pending;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (err_count < MaxPrinted) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    err_count++;
  endtask

  function automatic void clear_scan();
    scan_idx   = '0;
    free_len   = '0;
    run_found  = 1'b0;
    run_last   = '0;
    end_marked = 1'b0;
    end_idx    = '0;
    tail_free  = 1'b0;
    tail_first = '0;
  endfunction

  // Advance the scan by one slot; on the closing slot queue the placement decision.
  function automatic void track_free_runs(input logic [ByteW-1:0] fb,
                                          input logic [NeedW-1:0] need,
                                          input logic last);
    logic [IdxW-1:0] idx;
    logic            is_end;
    logic            is_free;
    result_t         res;
    idx     = scan_idx;
    is_end  = (fb == EndMark);
    is_free = is_end || (fb == UnusedMark);
    if (is_end && !end_marked) begin
      end_marked = 1'b1;
      end_idx    = idx;
    end
    if (!run_found) begin
      if (is_free) begin
        free_len = free_len + 1'b1;
        if (need != '0 && free_len == need) begin
          run_found = 1'b1;
          run_last  = idx;
        end
      end else begin
        free_len = '0;
      end
    end
    if (is_free) begin
      if (!tail_free) begin
        tail_free  = 1'b1;
        tail_first = idx;
      end
    end else begin
      tail_free = 1'b0;
    end
    if (!last && idx < LastIdx) begin
      scan_idx = idx + 1'b1;
      return;
    end
    res = '0;
    res.old_end = end_marked ? end_idx : '0;
    if (!end_marked) begin
      res.outcome = OutNoEnd;
    end else if (!run_found) begin
      res.outcome = OutNoRoom;
    end else if (end_idx > run_last) begin
      res.outcome   = OutPlaced;
      res.run_start = run_last - IdxW'(need) + IdxW'(1);
    end else if (tail_free && idx > run_last) begin
      res.outcome      = OutPlaced;
      res.run_start    = run_last - IdxW'(need) + IdxW'(1);
      res.relocate_end = 1'b1;
      res.new_end      = (tail_first > run_last) ? tail_first : run_last + IdxW'(1);
    end else begin
      res.outcome = OutNoRoom;
    end
    placement_q = {placement_q, res};
    clear_scan();
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (placement_q.size() == 0) begin
        flag_mismatch("result with no request pending, outcome", outcome_o, 0);
      end else begin
        pending = placement_q.pop_front();
        if (outcome_o !== pending.outcome)
          flag_mismatch("outcome", outcome_o, pending.outcome);
        if (run_start_o !== pending.run_start)
          flag_mismatch("run_start", run_start_o, pending.run_start);
        if (relocate_end_o !== pending.relocate_end)
          flag_mismatch("relocate_end", relocate_end_o, pending.relocate_end);
        if (old_end_o !== pending.old_end)
          flag_mismatch("old_end", old_end_o, pending.old_end);
        if (new_end_o !== pending.new_end)
          flag_mismatch("new_end", new_end_o, pending.new_end);
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Entered and left at a falling edge; valid stays up for a back-to-back request.
  task automatic send_slot(input logic [ByteW-1:0] fb, input logic [NeedW-1:0] need,
                           input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_byte_i   <= fb;
    slots_needed_i <= need;
    last_slot_i    <= last;
    do @(posedge clk_i); while (!in_ready_o);
    track_free_runs(fb, need, last);
    @(negedge clk_i);
  endtask

  task automatic wait_all_placed();
    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_first_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return UnusedMark;
    if (r < 55) return EndMark;
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic logic [NeedW-1:0] pick_need();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return NeedW'($urandom_range(1, 4));
    if (r < 88) return NeedW'($urandom_range(5, 12));
    if (r < 96) return NeedW'($urandom_range(13, 21));
    return NeedW'($urandom_range(0, 31));
  endfunction

  task automatic test_outcomes();
    // no end marker
    send_slot(UnusedMark, 5'd1, 1'b0);
    send_slot(8'h41, 5'd1, 1'b1);
    // end marker after the run
    send_slot(8'h41, 5'd2, 1'b0);
    send_slot(UnusedMark, 5'd2, 1'b0);
    send_slot(UnusedMark, 5'd2, 1'b0);
    send_slot(EndMark, 5'd2, 1'b1);
    // end marker inside the run, trailing free run starts in the run
    send_slot(EndMark, 5'd2, 1'b0);
    send_slot(UnusedMark, 5'd2, 1'b0);
    send_slot(UnusedMark, 5'd2, 1'b1);
    // trailing free run starts above the run
    send_slot(EndMark, 5'd1, 1'b0);
    send_slot(8'h41, 5'd1, 1'b0);
    send_slot(UnusedMark, 5'd1, 1'b0);
    send_slot(UnusedMark, 5'd1, 1'b1);
    // trailing run closed, nowhere to move the end
    send_slot(EndMark, 5'd2, 1'b0);
    send_slot(UnusedMark, 5'd2, 1'b0);
    send_slot(8'h7F, 5'd2, 1'b1);
  endtask

  task automatic test_need_extremes();
    send_slot(EndMark, 5'd0, 1'b1);
    send_slot(8'hFF, 5'd31, 1'b1);
    for (int i = 0; i < 21; i++) begin
      send_slot((i == 0) ? EndMark : UnusedMark, 5'd21, i == 20);
    end
    // need changes on the closing slot, run start wraps
    send_slot(EndMark, 5'd2, 1'b0);
    send_slot(UnusedMark, 5'd2, 1'b0);
    send_slot(UnusedMark, 5'd9, 1'b1);
  endtask

  task automatic test_random_scans(input int unsigned n_items, input bit with_idle);
    int unsigned      sent;
    int unsigned      len;
    logic [NeedW-1:0] need;
    sent    = 0;
    idle_on = with_idle;
    while (sent < n_items) begin
      need = pick_need();
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 2 * need + 6);
        for (int i = 0; i < len; i++) begin
          send_slot(pick_first_byte(), need, i == len - 1);
        end
      end else begin
        // broken scan: need drifts, bytes fully random, may not close
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_slot(ByteW'($urandom_range(0, 255)), NeedW'($urandom_range(0, 31)),
                    ($urandom_range(0, 3) == 0));
        end
      end
      sent += len;
    end
  endtask

  initial begin
    clear_scan();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_outcomes();
    test_need_extremes();
    wait_all_placed();
    test_random_scans(300, 1'b1);
    wait_all_placed();
    test_random_scans(150, 1'b0);
    test_random_scans(200, 1'b1);
    test_random_scans(100, 1'b0);
    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
